>>> hw/rtl/sh24_pkg.sv
// Shared types, constants and round function for the SipHash-2-4 block.
package sh24_pkg;

  localparam int WordWidth   = 64;
  localparam int CountWidth  = 4;
  localparam int LenWidth    = 8;
  localparam int CfgIdxWidth = 1;

  localparam logic [CountWidth-1:0] FullCount = CountWidth'(8);

  localparam logic [WordWidth-1:0] SipC0 = 64'h736f6d6570736575;
  localparam logic [WordWidth-1:0] SipC1 = 64'h646f72616e646f6d;
  localparam logic [WordWidth-1:0] SipC2 = 64'h6c7967656e657261;
  localparam logic [WordWidth-1:0] SipC3 = 64'h7465646279746573;
  localparam logic [WordWidth-1:0] FinalXor = 64'h00000000000000ff;

  localparam logic [CfgIdxWidth-1:0] RegKeyLow  = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegKeyHigh = 1'b1;

  typedef struct packed {
    logic [WordWidth-1:0] a;
    logic [WordWidth-1:0] b;
    logic [WordWidth-1:0] c;
    logic [WordWidth-1:0] d;
  } lanes_t;

  typedef enum logic [6:0] {
    OP_NONE     = 7'b0000001,
    OP_START    = 7'b0000010,
    OP_TAIL     = 7'b0000100,
    OP_ROUND_M  = 7'b0001000,
    OP_ROUND_FF = 7'b0010000,
    OP_ROUND    = 7'b0100000,
    OP_EMIT     = 7'b1000000
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

  function automatic lanes_t key_lanes(logic [WordWidth-1:0] klo, logic [WordWidth-1:0] khi);
    lanes_t v;
    v.a = klo ^ SipC0;
    v.b = khi ^ SipC1;
    v.c = klo ^ SipC2;
    v.d = khi ^ SipC3;
    return v;
  endfunction

  function automatic lanes_t sip_round(lanes_t v);
    lanes_t r;
    logic [WordWidth-1:0] a;
    logic [WordWidth-1:0] b;
    logic [WordWidth-1:0] c;
    logic [WordWidth-1:0] d;
    a = v.a + v.b;
    b = {v.b[50:0], v.b[63:51]} ^ a;
    a = {a[31:0], a[63:32]};
    c = v.c + v.d;
    d = {v.d[47:0], v.d[63:48]} ^ c;
    a = a + d;
    d = {d[42:0], d[63:43]} ^ a;
    c = c + b;
    b = {b[46:0], b[63:47]} ^ c;
    c = {c[31:0], c[63:32]};
    r.a = a;
    r.b = b;
    r.c = c;
    r.d = d;
    return r;
  endfunction

endpackage

>>> hw/rtl/sh24_stream_if.sv
// Valid/ready stream interfaces for message words and hash results.
interface sh24_msg_if import sh24_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [WordWidth-1:0]  message_word;
  logic [CountWidth-1:0] byte_count;
  logic                  last;

  modport source(output valid, message_word, byte_count, last, input ready);
  modport sink(input valid, message_word, byte_count, last, output ready);
endinterface

interface sh24_hash_if import sh24_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WordWidth-1:0] hash_value;

  modport source(output valid, hash_value, input ready);
  modport sink(input valid, hash_value, output ready);
endinterface

>>> hw/rtl/sh24_ctrl.sv
// Sequencer for compression, tail block, finalization and result hand-off.
module sh24_ctrl import sh24_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_last,
  input  logic [CountWidth-1:0] in_count,
  output logic                  in_ready,
  output dp_cmd_t               cmd,
  input  dp_sts_t               sts
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_COMP2 = 5'b00010,
    S_TAIL  = 5'b00100,
    S_FIN   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic       tail_pending;
  logic       tail_pending_next;
  logic       final_pending;
  logic       final_pending_next;
  logic [1:0] fin_cnt;
  logic [1:0] fin_cnt_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next         = state;
    tail_pending_next  = tail_pending;
    final_pending_next = final_pending;
    fin_cnt_next       = fin_cnt;
    cmd.op             = OP_NONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.op             = OP_START;
          final_pending_next = in_last;
          tail_pending_next  = in_last && (in_count >= FullCount);
          state_next         = S_COMP2;
        end
      end
      S_COMP2: begin
        cmd.op = OP_ROUND_M;
        if (tail_pending) begin
          tail_pending_next = 1'b0;
          state_next        = S_TAIL;
        end else if (final_pending) begin
          fin_cnt_next = 2'd0;
          state_next   = S_FIN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_TAIL: begin
        cmd.op     = OP_TAIL;
        state_next = S_COMP2;
      end
      S_FIN: begin
        cmd.op       = (fin_cnt == 2'd0) ? OP_ROUND_FF : OP_ROUND;
        fin_cnt_next = fin_cnt + 2'd1;
        if (fin_cnt == 2'd3) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.op             = OP_EMIT;
          final_pending_next = 1'b0;
          state_next         = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tail_pending  <= 1'b0;
      final_pending <= 1'b0;
      fin_cnt       <= 2'd0;
    end else begin
      state         <= state_next;
      tail_pending  <= tail_pending_next;
      final_pending <= final_pending_next;
      fin_cnt       <= fin_cnt_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_COMP2)
    else $error("accepted item did not start compression");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |-> !sts.out_busy)
    else $error("result written over a waiting result");

  a_tail_needs_final: assert property (@(posedge clk) disable iff (rst)
    tail_pending |-> final_pending)
    else $error("tail block pending outside a final item");

  a_fin_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && fin_cnt == 2'd3) |=> state == S_EMIT)
    else $error("finalization did not end in emit");

endmodule

>>> hw/rtl/sh24_datapath.sv
// Lane registers, key registers, message block and result register.
module sh24_datapath import sh24_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [WordWidth-1:0]   cfg_data,
  input  logic [WordWidth-1:0]   in_word,
  input  logic [CountWidth-1:0]  in_count,
  input  logic                   in_last,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [WordWidth-1:0]   out_hash
);

  lanes_t                lanes;
  lanes_t                lanes_next;
  lanes_t                round_in;
  lanes_t                round_out;
  logic [WordWidth-1:0]  key_low;
  logic [WordWidth-1:0]  key_high;
  logic [WordWidth-1:0]  key_low_next;
  logic [WordWidth-1:0]  key_high_next;
  logic [LenWidth-1:0]   len;
  logic [LenWidth-1:0]   len_next;
  logic [WordWidth-1:0]  m;
  logic [WordWidth-1:0]  m_next;
  logic                  full_word;
  logic [LenWidth-1:0]   start_len;
  logic [WordWidth-1:0]  masked_word;
  logic [WordWidth-1:0]  start_msg;
  logic [WordWidth-1:0]  tail_msg;
  logic                  out_valid_next;
  logic [WordWidth-1:0]  out_hash_next;

  assign full_word = !in_last || (in_count >= FullCount);
  assign start_len = full_word ? len + LenWidth'(8) : len + LenWidth'(in_count);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked_word[8*i +: 8] = (CountWidth'(i) < in_count) ? in_word[8*i +: 8] : 8'h00;
    end
  end

  assign start_msg = full_word ? in_word : (masked_word | {start_len, {(WordWidth-LenWidth){1'b0}}});
  assign tail_msg  = {len, {(WordWidth-LenWidth){1'b0}}};

  always_comb begin
    round_in = lanes;
    case (cmd.op)
      OP_START:    round_in.d = lanes.d ^ start_msg;
      OP_TAIL:     round_in.d = lanes.d ^ tail_msg;
      OP_ROUND_FF: round_in.c = lanes.c ^ FinalXor;
      default:     round_in = lanes;
    endcase
  end

  assign round_out = sip_round(round_in);

  assign sts.out_busy = out_valid && !out_ready;

  always_comb begin
    lanes_next     = lanes;
    len_next       = len;
    m_next         = m;
    key_low_next   = key_low;
    key_high_next  = key_high;
    out_valid_next = out_valid && !out_ready;
    out_hash_next  = out_hash;
    case (cmd.op)
      OP_START: begin
        lanes_next = round_out;
        m_next     = start_msg;
        len_next   = start_len;
      end
      OP_TAIL: begin
        lanes_next = round_out;
        m_next     = tail_msg;
      end
      OP_ROUND_M: begin
        lanes_next   = round_out;
        lanes_next.a = round_out.a ^ m;
      end
      OP_ROUND_FF, OP_ROUND: begin
        lanes_next = round_out;
      end
      OP_EMIT: begin
        out_valid_next = 1'b1;
        out_hash_next  = lanes.a ^ lanes.b ^ lanes.c ^ lanes.d;
        lanes_next     = key_lanes(key_low, key_high);
        len_next       = '0;
      end
      default: begin
        lanes_next = lanes;
      end
    endcase
    if (cfg_we) begin
      case (cfg_index)
        RegKeyLow:  key_low_next  = cfg_data;
        RegKeyHigh: key_high_next = cfg_data;
        default:    key_low_next  = key_low;
      endcase
      lanes_next = key_lanes(key_low_next, key_high_next);
      len_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low   <= '0;
      key_high  <= '0;
      lanes     <= key_lanes('0, '0);
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      key_low   <= key_low_next;
      key_high  <= key_high_next;
      lanes     <= lanes_next;
      len       <= len_next;
      out_valid <= out_valid_next;
    end
    m        <= m_next;
    out_hash <= out_hash_next;
  end

endmodule

>>> hw/rtl/siphash_2_4_keyed_hash.sv
// Top level of the SipHash-2-4 keyed hash block.
// Usage:
//   msg carries message words with valid/ready; byte_count is used only on the
//   item with last set (0..8 bytes, larger values count as 8).
//   digest carries one 64-bit hash_value per message, after its last item.
//   cfg_we/cfg_index/cfg_data write key_low (index 0) or key_high (index 1);
//   a write reloads the lanes and drops any message in progress. Write only
//   while the block is idle.
// Timing: one SipRound per cycle in a shared round unit.
//   Word that is not last: start round, round with m, then the next item.
//   Last item with 0..7 bytes: those rounds, finalization rounds, then emit.
//   Last item with 8 bytes: as above, with a tail block and its rounds added.
// The result register holds the hash while digest.ready is low; the next
// message streams in meanwhile, and its own result waits for the slot.
// Reset: keys clear to zero, lanes load the key-derived constants, no result.
module siphash_2_4_keyed_hash import sh24_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  sh24_msg_if.sink               msg,
  sh24_hash_if.source            digest,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [WordWidth-1:0]   cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sh24_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (msg.valid),
    .in_last  (msg.last),
    .in_count (msg.byte_count),
    .in_ready (msg.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sh24_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (msg.message_word),
    .in_count  (msg.byte_count),
    .in_last   (msg.last),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (digest.valid),
    .out_ready (digest.ready),
    .out_hash  (digest.hash_value)
  );

endmodule
